FILE: design/nrds_pkg.sv
// ----------------------------------------------------------------------------
// nrds_pkg: shared types and constants of the nearest record distance sorter
// Holds the fixed field widths, the register indexes and the cell control
// struct that the sorter cells share.
// ----------------------------------------------------------------------------
`default_nettype none
package nrds_pkg;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned NFEAT   = 8;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_ACCOMMODATES = 3'd0;
  localparam logic [IDX_W-1:0] REG_BEDROOMS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_BATHROOMS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_BEDS         = 3'd3;
  localparam logic [IDX_W-1:0] REG_PRICE        = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_NIGHTS   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_NIGHTS   = 3'd6;
  localparam logic [IDX_W-1:0] REG_REVIEWS      = 3'd7;

  typedef logic [FIELD_W-1:0] feat_t;

  // control broadcast to every cell of the sorted list
  typedef struct packed {
    logic ins;    // insert a new entry this cycle
    logic shift;  // drain: every cell takes its right neighbor's entry
    logic clr;    // every cell empties; the sorter ties it low
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: design/nrds_if.sv
// ----------------------------------------------------------------------------
// nrds_in_if / nrds_out_if: request channels of the sorter
// Valid/ready channels carrying one input record or one sorted result.
// ----------------------------------------------------------------------------
`default_nettype none
interface nrds_in_if;
  logic                       valid;
  logic                       ready;
  logic [nrds_pkg::ID_W-1:0]  record_id;
  nrds_pkg::feat_t            accommodates;
  nrds_pkg::feat_t            bedrooms;
  nrds_pkg::feat_t            bathrooms;
  nrds_pkg::feat_t            beds;
  nrds_pkg::feat_t            price;
  nrds_pkg::feat_t            min_nights;
  nrds_pkg::feat_t            max_nights;
  nrds_pkg::feat_t            review_count;
  logic                       last_record;
  modport source (output valid, record_id, accommodates, bedrooms, bathrooms, beds,
                  price, min_nights, max_nights, review_count, last_record,
                  input ready);
  modport sink (input valid, record_id, accommodates, bedrooms, bathrooms, beds,
                price, min_nights, max_nights, review_count, last_record,
                output ready);
endinterface

interface nrds_out_if;
  logic                         valid;
  logic                         ready;
  logic [nrds_pkg::ID_W-1:0]    out_id;
  logic [nrds_pkg::DIST_W-1:0]  out_distance;
  logic                         out_last;
  logic [nrds_pkg::DIST_W-1:0]  mean_distance;
  logic                         records_dropped;
  modport source (output valid, out_id, out_distance, out_last, mean_distance,
                  records_dropped, input ready);
  modport sink (input valid, out_id, out_distance, out_last, mean_distance,
                records_dropped, output ready);
endinterface
`default_nettype wire

FILE: design/nrds_isqrt.sv
// ----------------------------------------------------------------------------
// nrds_isqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module nrds_isqrt #(
  parameter int unsigned IN_W = 36
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [IN_W-1:0]     radicand,
  output      logic                done,
  output      logic [IN_W/2-1:0]   root
);
  localparam int unsigned RW  = IN_W / 2;
  localparam int unsigned CW  = $clog2(RW + 1);
  localparam int unsigned REM_W = RW + 2;

  logic [IN_W-1:0]   val;
  logic [REM_W-1:0]  rem;
  logic [RW-1:0]     acc;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  cand;

  always_comb begin
    trial = {rem[REM_W-3:0], val[IN_W-1 -: 2]};
    cand  = {acc, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
        val  <= radicand;
        rem  <= '0;
        acc  <= '0;
      end else if (busy) begin
        val <= {val[IN_W-3:0], 2'b00};
        if (trial >= cand) begin
          rem <= trial - cand;
          acc <= {acc[RW-2:0], 1'b1};
        end else begin
          rem <= trial;
          acc <= {acc[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = acc;
endmodule
`default_nettype wire

FILE: design/nrds_cell.sv
// ----------------------------------------------------------------------------
// nrds_cell: one slot of the systolic sorted list
// Keeps one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's entry; on drain the right neighbor's entry; on clear it empties.
// ----------------------------------------------------------------------------
`default_nettype none
module nrds_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nrds_pkg::cell_ctl_t           ctl,
  input  wire logic [nrds_pkg::ID_W-1:0]     new_id,
  input  wire logic [nrds_pkg::DIST_W-1:0]   new_dist,
  input  wire logic                          left_full,
  input  wire logic                          left_gt,
  input  wire logic [nrds_pkg::ID_W-1:0]     left_id,
  input  wire logic [nrds_pkg::DIST_W-1:0]   left_dist,
  input  wire logic                          right_full,
  input  wire logic [nrds_pkg::ID_W-1:0]     right_id,
  input  wire logic [nrds_pkg::DIST_W-1:0]   right_dist,
  output      logic                          full,
  output      logic                          gt,
  output      logic [nrds_pkg::ID_W-1:0]     id,
  output      logic [nrds_pkg::DIST_W-1:0]   distance
);
  // stored entry strictly greater than the new one: it moves right
  assign gt = full && (distance > new_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctl.clr) begin
      full <= 1'b0;
    end else if (ctl.shift) begin
      full     <= right_full;
      id       <= right_id;
      distance <= right_dist;
    end else if (ctl.ins) begin
      // only the first empty cell takes the new entry when nothing moves
      priority if (left_gt) begin
        full     <= 1'b1;
        id       <= left_id;
        distance <= left_dist;
      end else if (gt || (!full && left_full)) begin
        full     <= 1'b1;
        id       <= new_id;
        distance <= new_dist;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/nearest_record_distance_sorter.sv
// ----------------------------------------------------------------------------
// nearest_record_distance_sorter: distance to a query and stable sort
// Computes isqrt of the squared feature distance of each record and keeps the
// batch in a chain of sorted cells; the last record drains the batch.
// ----------------------------------------------------------------------------
// channel  dir  handshake    payload
// in_req   in   valid/ready  record_id, eight features, last_record
// out_req  out  valid/ready  out_id, out_distance, out_last, mean, dropped
// cfg      in   cfg_we       cfg_index, cfg_data (8 x 16 bit query)
//
// a record is accepted only while idle; the squared sum (two multipliers,
// four steps, product and sum registered), the bit-serial square root and
// one insert into the cell chain follow before the next record is taken.
// the last record then runs the mean divider; the drain then gives one result
// per cycle the sink takes; input stalls until the drain ends.
// reset is synchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_record_distance_sorter #(
  parameter int unsigned CAPACITY     = 32,
  parameter int unsigned FEATURE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  nrds_in_if.sink                                  in_req,
  nrds_out_if.source                               out_req,
  input  wire logic                                cfg_we,
  input  wire logic [nrds_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [nrds_pkg::FIELD_W-1:0]        cfg_data
);
  // features wider than the ports carry add nothing
  localparam int unsigned FB    = (FEATURE_BITS < nrds_pkg::FIELD_W) ?
                                  FEATURE_BITS : nrds_pkg::FIELD_W;
  localparam int unsigned SQ_W  = 2 * FB + 3;
  localparam int unsigned RAD_W = SQ_W + (SQ_W % 2);
  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned TOT_W = RT_W + CNT_W;
  localparam int unsigned DCW   = $clog2(TOT_W + 1);
  localparam int unsigned DW    = nrds_pkg::DIST_W;
  localparam int unsigned IW    = nrds_pkg::ID_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0] state;

  // query registers
  logic [FB-1:0] query [nrds_pkg::NFEAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nrds_pkg::NFEAT; i++) query[i] <= '0;
    end else if (cfg_we) begin
      query[cfg_index] <= cfg_data[FB-1:0];
    end
  end

  // latched record
  logic [FB-1:0] feat [nrds_pkg::NFEAT];
  logic [IW-1:0] rec_id;
  logic          rec_last;
  logic          in_fire;
  assign in_req.ready = (state == S_IDLE);
  assign in_fire = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_id   <= in_req.record_id;
      rec_last <= in_req.last_record;
      feat[0]  <= in_req.accommodates[FB-1:0];
      feat[1]  <= in_req.bedrooms[FB-1:0];
      feat[2]  <= in_req.bathrooms[FB-1:0];
      feat[3]  <= in_req.beds[FB-1:0];
      feat[4]  <= in_req.price[FB-1:0];
      feat[5]  <= in_req.min_nights[FB-1:0];
      feat[6]  <= in_req.max_nights[FB-1:0];
      feat[7]  <= in_req.review_count[FB-1:0];
    end
  end

  // squared sum: two features per cycle, product registered before the add
  logic [2:0]      sstep;
  logic [FB-1:0]   da, db;
  logic [2*FB-1:0] pa, pb;
  logic [SQ_W-1:0] sq_sum;
  logic            pvalid;
  logic [1:0]      pair;
  assign pair = sstep[1:0];

  always_comb begin
    logic [FB-1:0] qa, qb, fa, fb;
    qa = query[{pair, 1'b0}];
    qb = query[{pair, 1'b1}];
    fa = feat[{pair, 1'b0}];
    fb = feat[{pair, 1'b1}];
    da = (qa > fa) ? qa - fa : fa - qa;
    db = (qb > fb) ? qb - fb : fb - qb;
  end

  logic sq_start;
  logic sq_done;
  logic [RT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      sstep  <= '0;
    end else begin
      pvalid <= (state == S_SUM) && !sstep[2];
      if (state == S_SUM && !sstep[2]) begin
        pa    <= da * da;
        pb    <= db * db;
        sstep <= sstep + 1'b1;
      end else if (state != S_SUM) begin
        sstep <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) sq_sum <= '0;
    else if (pvalid) sq_sum <= sq_sum + SQ_W'(pa) + SQ_W'(pb);
  end

  assign sq_start = (state == S_SUM) && sstep[2] && !pvalid;

  nrds_isqrt #(.IN_W(RAD_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (RAD_W'(sq_sum)),
    .done     (sq_done),
    .root     (root)
  );

  logic [DW-1:0] rec_dist;
  always_ff @(posedge clk) begin
    if (sq_done) rec_dist <= DW'(root);
  end

  // batch bookkeeping
  logic [CNT_W-1:0] count;
  logic [TOT_W-1:0] total;
  logic             ovf;
  logic             room;
  assign room = (count < CNT_W'(CAPACITY));

  // cell chain
  nrds_pkg::cell_ctl_t ctl;
  logic          c_full [CAPACITY+1];
  logic          c_gt   [CAPACITY];
  logic [IW-1:0] c_id   [CAPACITY+1];
  logic [DW-1:0] c_dist [CAPACITY+1];

  assign ctl = '{ins:   (state == S_INS) && room,
                 shift: (state == S_DRAIN) && out_req.ready && out_req.valid,
                 clr:   1'b0};

  // sentinel past the last cell
  assign c_full[CAPACITY] = 1'b0;
  assign c_id[CAPACITY]   = '0;
  assign c_dist[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic          lf, lg;
    logic [IW-1:0] li;
    logic [DW-1:0] ld;
    if (g == 0) begin : g_head
      // nothing to the left: seen as a full entry that never moves
      assign lf = 1'b1;
      assign lg = 1'b0;
      assign li = '0;
      assign ld = '0;
    end else begin : g_body
      assign lf = c_full[g-1];
      assign lg = c_gt[g-1];
      assign li = c_id[g-1];
      assign ld = c_dist[g-1];
    end
    nrds_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_id     (rec_id),
      .new_dist   (rec_dist),
      .left_full  (lf),
      .left_gt    (lg),
      .left_id    (li),
      .left_dist  (ld),
      .right_full (c_full[g+1]),
      .right_id   (c_id[g+1]),
      .right_dist (c_dist[g+1]),
      .full       (c_full[g]),
      .gt         (c_gt[g]),
      .id         (c_id[g]),
      .distance   (c_dist[g])
    );
  end

  // mean: restoring divider, one quotient bit per cycle
  logic [TOT_W-1:0] dq;
  logic [CNT_W:0]   drem;
  logic [DCW-1:0]   dcnt;
  logic [CNT_W:0]   dtrial;
  logic [DW-1:0]    mean;
  logic             final_ovf;
  logic [CNT_W-1:0] left;
  assign dtrial = {drem[CNT_W-1:0], dq[TOT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      ovf   <= 1'b0;
      left  <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_SUM;
        S_SUM:  if (sq_start) state <= S_ROOT;
        S_ROOT: if (sq_done) state <= S_INS;
        S_INS: begin
          if (room) begin
            count <= count + 1'b1;
            total <= total + TOT_W'(rec_dist);
          end else begin
            ovf <= 1'b1;
          end
          if (rec_last) begin
            state <= S_DIV;
            dq    <= room ? total + TOT_W'(rec_dist) : total;
            drem  <= '0;
            dcnt  <= DCW'(TOT_W);
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (dtrial >= {1'b0, count}) begin
            drem <= dtrial - {1'b0, count};
            dq   <= {dq[TOT_W-2:0], 1'b1};
          end else begin
            drem <= dtrial;
            dq   <= {dq[TOT_W-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            state     <= S_DRAIN;
            left      <= count;
            final_ovf <= ovf;
          end
        end
        S_DRAIN: begin
          if (ctl.shift) begin
            left <= left - 1'b1;
            if (left == CNT_W'(1)) begin
              state <= S_IDLE;
              count <= '0;
              total <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mean = DW'(dq);

  logic is_fin;
  assign is_fin = (left == CNT_W'(1));
  assign out_req.valid           = (state == S_DRAIN);
  assign out_req.out_id          = c_id[0];
  assign out_req.out_distance    = c_dist[0];
  assign out_req.out_last        = is_fin;
  assign out_req.mean_distance   = is_fin ? mean : '0;
  assign out_req.records_dropped = is_fin && final_ovf;

`ifndef SYNTHESIS
  a_drain_has_entry: assert property (@(posedge clk) disable iff (rst)
    out_req.valid |-> c_full[0])
    else $error("drain with empty head cell");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count past capacity");
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (ctl.shift && is_fin) |=> (count == '0 && !ovf))
    else $error("batch state not cleared after drain");
`endif
endmodule
`default_nettype wire
